/* hdl/bdq_pkg.sv */
// shared constants, command codes and control types for the bounded deque
`timescale 1ns / 1ps

package bdq_pkg;

    // default capacity in words
    localparam int DEPTH_DEF = 16;

    // fixed field widths
    localparam int WORD_W   = 16;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // command codes (other codes act as a query)
    localparam logic [CMD_W-1:0] CMD_PUSH_LEFT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_RIGHT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LEFT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_RIGHT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic fill;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_read;
    } dp_status_t;

endpackage

/* hdl/bounded_deque_unit.sv */
// top level of the bounded double-ended queue of signed words
`timescale 1ns / 1ps

// Bounded deque of signed 16-bit words with room for DEPTH words. Each item carries a
// command (push left, push right, pop left, pop right, or query for any other code) and
// returns one result with the pushed or popped word, a status (done, refused because full,
// refused because empty), the count after the command and the left-end and right-end words
// (zero when empty). Words live in a circular buffer in a ram with one write port and one
// registered read port; the two end words are cached in registers. After acceptance an item
// passes the exec state, then the fill state for a pop that leaves words behind, since the
// new end word must be fetched from the ram, then the done state, which loads its result once
// the output register is free; the next item is accepted the cycle after the result is
// loaded, and none is taken before that. A finished result sits in the output register while
// the next item is taken; a result waits only when the previous one has not yet been taken.
// No clearing pass is needed after reset.
module bounded_deque_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]           s_command,
    input  logic signed [bdq_pkg::WORD_W-1:0]   s_push_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_result_value,
    output logic [bdq_pkg::STATUS_W-1:0]        m_status,
    output logic [CNT_W-1:0]                    m_entry_count,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_left_value,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_right_value
);

    bdq_pkg::ctrl_cmd_t  ctrl_cmd;
    bdq_pkg::dp_status_t dp_status;

    // sequencer
    bdq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // storage and result datapath
    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_cmd       (ctrl_cmd),
        .dp_status      (dp_status),
        .s_command      (s_command),
        .s_push_value   (s_push_value),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count),
        .m_left_value   (m_left_value),
        .m_right_value  (m_right_value)
    );

    // count never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above capacity");

    // a refused command returns a zero word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != bdq_pkg::ST_DONE)) |-> (m_result_value == '0))
        else $error("refused command returned a nonzero word");

    // an empty queue shows zero at both ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_entry_count == '0)) |-> ((m_left_value == '0) && (m_right_value == '0)))
        else $error("empty queue shows nonzero end words");

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

endmodule

/* hdl/bdq_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bdq_ctrl.sv */
// sequencing state machine and result valid flag for the bounded deque
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  bdq_pkg::dp_status_t   dp_status,
    output bdq_pkg::ctrl_cmd_t    ctrl_cmd
);

    localparam logic [1:0] STATE_IDLE = 2'd0;
    localparam logic [1:0] STATE_EXEC = 2'd1;
    localparam logic [1:0] STATE_FILL = 2'd2;
    localparam logic [1:0] STATE_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // output register can take a new result
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctrl_cmd     = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            STATE_IDLE: begin
                if (s_valid) begin
                    ctrl_cmd.latch_in = 1'b1;
                    state_next        = STATE_EXEC;
                end
            end
            STATE_EXEC: begin
                ctrl_cmd.exec = 1'b1;
                state_next    = dp_status.need_read ? STATE_FILL : STATE_DONE;
            end
            STATE_FILL: begin
                ctrl_cmd.fill = 1'b1;
                state_next    = STATE_DONE;
            end
            STATE_DONE: begin
                if (out_free) begin
                    ctrl_cmd.load_out = 1'b1;
                    m_valid_next      = 1'b1;
                    state_next        = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == STATE_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* hdl/bdq_datapath.sv */
// pointers, count, end-word caches, word storage and result register
`timescale 1ns / 1ps

module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bdq_pkg::ctrl_cmd_t                  ctrl_cmd,
    output bdq_pkg::dp_status_t                 dp_status,
    input  logic [bdq_pkg::CMD_W-1:0]           s_command,
    input  logic signed [bdq_pkg::WORD_W-1:0]   s_push_value,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_result_value,
    output logic [bdq_pkg::STATUS_W-1:0]        m_status,
    output logic [CNT_W-1:0]                    m_entry_count,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_left_value,
    output logic signed [bdq_pkg::WORD_W-1:0]   m_right_value
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control state
    logic [PTR_W-1:0] left_pos_reg, left_pos_next;
    logic [PTR_W-1:0] right_pos_reg, right_pos_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // payload state
    logic [bdq_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [bdq_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [bdq_pkg::WORD_W-1:0]   left_val_reg, left_val_next;
    logic [bdq_pkg::WORD_W-1:0]   right_val_reg, right_val_next;
    logic [bdq_pkg::WORD_W-1:0]   res_reg, res_next;
    logic [bdq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [bdq_pkg::WORD_W-1:0]   out_res_reg, out_res_next;
    logic [bdq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0]             out_count_reg, out_count_next;
    logic [bdq_pkg::WORD_W-1:0]   out_left_reg, out_left_next;
    logic [bdq_pkg::WORD_W-1:0]   out_right_reg, out_right_next;

    // decode and storage port signals
    logic                       is_push_l, is_push_r, is_pop_l, is_pop_r;
    logic                       full, empty;
    logic [PTR_W-1:0]           left_dec, left_inc, right_dec, right_inc;
    logic                       ram_we;
    logic [PTR_W-1:0]           ram_waddr, ram_raddr;
    logic [bdq_pkg::WORD_W-1:0] ram_rdata;

    assign is_push_l = (cmd_reg == bdq_pkg::CMD_PUSH_LEFT);
    assign is_push_r = (cmd_reg == bdq_pkg::CMD_PUSH_RIGHT);
    assign is_pop_l  = (cmd_reg == bdq_pkg::CMD_POP_LEFT);
    assign is_pop_r  = (cmd_reg == bdq_pkg::CMD_POP_RIGHT);
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);

    // circular pointer steps
    assign left_dec  = (left_pos_reg == '0) ? LAST_PTR : PTR_W'(left_pos_reg - 1'b1);
    assign left_inc  = (left_pos_reg == LAST_PTR) ? '0 : PTR_W'(left_pos_reg + 1'b1);
    assign right_dec = (right_pos_reg == '0) ? LAST_PTR : PTR_W'(right_pos_reg - 1'b1);
    assign right_inc = (right_pos_reg == LAST_PTR) ? '0 : PTR_W'(right_pos_reg + 1'b1);

    // a pop that leaves words behind must fetch the new end word
    assign dp_status.need_read = (is_pop_l || is_pop_r) && (count_reg > CNT_W'(1));

    // storage access
    assign ram_we    = ctrl_cmd.exec && !full && (is_push_l || is_push_r);
    assign ram_waddr = is_push_l ? left_dec : right_inc;
    assign ram_raddr = is_pop_l ? left_inc : right_dec;

    bdq_ram #(
        .WIDTH (bdq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (word_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // command execution and result staging
    always_comb begin
        cmd_next        = cmd_reg;
        word_next       = word_reg;
        left_pos_next   = left_pos_reg;
        right_pos_next  = right_pos_reg;
        count_next      = count_reg;
        left_val_next   = left_val_reg;
        right_val_next  = right_val_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        out_res_next    = out_res_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;

        if (ctrl_cmd.latch_in) begin
            cmd_next  = s_command;
            word_next = s_push_value;
        end

        if (ctrl_cmd.exec) begin
            res_next    = '0;
            status_next = bdq_pkg::ST_DONE;
            if (is_push_l || is_push_r) begin
                if (full) begin
                    status_next = bdq_pkg::ST_FULL;
                end else begin
                    res_next   = word_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                    if (is_push_l) begin
                        left_pos_next = left_dec;
                        left_val_next = word_reg;
                        if (empty) begin
                            right_val_next = word_reg;
                        end
                    end else begin
                        right_pos_next = right_inc;
                        right_val_next = word_reg;
                        if (empty) begin
                            left_val_next = word_reg;
                        end
                    end
                end
            end else if (is_pop_l || is_pop_r) begin
                if (empty) begin
                    status_next = bdq_pkg::ST_EMPTY;
                end else begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    if (is_pop_l) begin
                        res_next      = left_val_reg;
                        left_pos_next = left_inc;
                    end else begin
                        res_next       = right_val_reg;
                        right_pos_next = right_dec;
                    end
                end
            end
        end

        // new end word arrives from storage
        if (ctrl_cmd.fill) begin
            if (is_pop_l) begin
                left_val_next = ram_rdata;
            end else begin
                right_val_next = ram_rdata;
            end
        end

        // result into the output register, ends read as zero when empty
        if (ctrl_cmd.load_out) begin
            out_res_next    = res_reg;
            out_status_next = status_reg;
            out_count_next  = count_reg;
            out_left_next   = empty ? '0 : left_val_reg;
            out_right_next  = empty ? '0 : right_val_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_pos_reg  <= '0;
            right_pos_reg <= LAST_PTR;
            count_reg     <= '0;
        end else begin
            left_pos_reg  <= left_pos_next;
            right_pos_reg <= right_pos_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        word_reg       <= word_next;
        left_val_reg   <= left_val_next;
        right_val_reg  <= right_val_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_res_reg    <= out_res_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
    end

    assign m_result_value = out_res_reg;
    assign m_status       = out_status_reg;
    assign m_entry_count  = out_count_reg;
    assign m_left_value   = out_left_reg;
    assign m_right_value  = out_right_reg;

endmodule
